[rtl/interval_event_counter_ring_top_defines.svh]
// Assertion macros for the interval event counter ring.
`ifndef INTERVAL_EVENT_COUNTER_RING_TOP_DEFINES_SVH
`define INTERVAL_EVENT_COUNTER_RING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, held off during reset
`define IECR_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("interval event counter ring: assertion failed");
// Clocked check that also holds through reset
`define IECR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("interval event counter ring: assertion failed");
`else
`define IECR_ASSERT_CLK(lbl, prop)
`define IECR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/iecr_pkg.sv]
package iecr_pkg;

  localparam int NUM_SLOTS     = 8;
  localparam int NUM_TYPES     = 16;
  localparam int COUNTER_WIDTH = 32;
  localparam int VALUE_W       = 32;
  localparam int SLOT_W        = 3;
  localparam int TYPE_W        = 4;
  localparam int FILL_W        = 4;
  localparam int ADDR_W        = SLOT_W + TYPE_W;
  localparam int DEPTH         = NUM_SLOTS * NUM_TYPES;

  localparam logic [1:0] MODE_COUNT   = 2'd0;
  localparam logic [1:0] MODE_ADVANCE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TYPE_W-1:0] event_type;
    logic [SLOT_W-1:0] read_interval;
    logic [TYPE_W-1:0] read_type;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               read_valid;
    logic [SLOT_W-1:0]  current_slot;
    logic [FILL_W-1:0]  filled_slots;
  } res_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

[rtl/interval_event_counter_ring_top.sv]
// Ring of interval event counters: count, advance and read requests. A request
// is taken when start is high and busy is low; busy then stays high in EXEC,
// so a new request is taken only once the last one is through, due to
// the registered read of the counter memory ahead of increment and write-back.
// The result appears on result with done high for exactly one cycle, the
// first cycle in which busy is low again; the receiver cannot stall it and
// must take it then. A request may be started in that same cycle. Reset clears
// the store at once through per-counter valid flags, with no clearing pass.
`include "interval_event_counter_ring_top_defines.svh"

module interval_event_counter_ring_top
  import iecr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output res_t result
);

  cmd_t cmd;

  iecr_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd)
  );

  iecr_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .req   (req),
    .done  (done),
    .result(result)
  );

  // Check controller and datapath timing against each other
  `IECR_ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy)
  `IECR_ASSERT_CLK(a_exec_done, cmd.exec |=> done)
  `IECR_ASSERT_CLK(a_done_idle, !(done && busy))
  `IECR_ASSERT_CLK(a_fill_sat, done |-> (int'(result.filled_slots) <= NUM_SLOTS))
  `IECR_ASSERT_CLK(a_zero_invalid, (done && !result.read_valid) |-> (result.read_value == '0))

endmodule

[rtl/iecr_ram.sv]
module iecr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/iecr_ctrl.sv]
module iecr_ctrl
  import iecr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // Take a request in idle, finish it in the following cycle
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != S_IDLE);
  assign cmd.load = start && (state == S_IDLE);
  assign cmd.exec = (state == S_EXEC);

endmodule

[rtl/iecr_dp.sv]
module iecr_dp
  import iecr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req,
  output logic done,
  output res_t result
);

  req_t                     req_q;
  logic [ADDR_W-1:0]        raddr;
  logic [ADDR_W-1:0]        addr_q;
  logic [COUNTER_WIDTH-1:0] rdata;
  logic [COUNTER_WIDTH-1:0] cur_val;
  logic [COUNTER_WIDTH-1:0] wdata;
  logic [DEPTH-1:0]         vbits;
  logic [SLOT_W-1:0]        slot_ptr;
  logic [SLOT_W-1:0]        slot_ptr_next;
  logic [FILL_W-1:0]        filled;
  logic [FILL_W-1:0]        filled_next;
  logic                     we;
  logic                     rd_ok;
  logic                     is_adv;

  // Pick the counter address: the read target or the current slot
  always_comb begin
    if (req.mode == MODE_READ) begin
      raddr = {req.read_interval, req.read_type};
    end else begin
      raddr = {slot_ptr, req.event_type};
    end
  end

  // Hold the request while the memory read completes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q  <= req;
      addr_q <= raddr;
    end
  end

  iecr_ram #(
    .WIDTH(COUNTER_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(addr_q),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // An entry not written since its slot was cleared reads as zero
  assign cur_val = vbits[addr_q] ? rdata : '0;
  assign wdata   = cur_val + COUNTER_WIDTH'(1);

  // Work out the effect of the held request
  always_comb begin
    slot_ptr_next = slot_ptr;
    filled_next   = filled;
    we            = 1'b0;
    rd_ok         = 1'b0;
    is_adv        = 1'b0;
    case (req_q.mode)
      MODE_COUNT: begin
        we = cmd.exec && (int'(req_q.event_type) < NUM_TYPES);
      end
      MODE_ADVANCE: begin
        is_adv = cmd.exec;
        if (int'(slot_ptr) == NUM_SLOTS - 1) begin
          slot_ptr_next = '0;
        end else begin
          slot_ptr_next = slot_ptr + SLOT_W'(1);
        end
        if (int'(filled) < NUM_SLOTS) begin
          filled_next = filled + FILL_W'(1);
        end
      end
      MODE_READ: begin
        rd_ok = (FILL_W'(req_q.read_interval) < filled)
             && (int'(req_q.read_interval) < NUM_SLOTS)
             && (int'(req_q.read_type) < NUM_TYPES);
      end
      default: ;
    endcase
  end

  // Mark written entries, drop the whole new slot on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else begin
      if (we) begin
        vbits[addr_q] <= 1'b1;
      end
      if (is_adv) begin
        for (int t = 0; t < NUM_TYPES; t++) begin
          vbits[{slot_ptr_next, TYPE_W'(t)}] <= 1'b0;
        end
      end
    end
  end

  // Advance the ring pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ptr <= '0;
      filled   <= '0;
    end else if (cmd.exec) begin
      slot_ptr <= slot_ptr_next;
      filled   <= filled_next;
    end
  end

  // Register done from the execute command
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result.read_value   <= rd_ok ? VALUE_W'(cur_val) : '0;
      result.read_valid   <= rd_ok;
      result.current_slot <= slot_ptr_next;
      result.filled_slots <= filled_next;
    end
  end

endmodule

[test/interval_event_counter_ring_checker.sv]
module interval_event_counter_ring_checker
  import iecr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  logic done,
  input  res_t result,
  output int   errors,
  output int   pending,
  output int   valid_reads,
  output int   advances
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the counter store and ring position
  logic [COUNTER_WIDTH-1:0] tally [NUM_SLOTS][NUM_TYPES];
  logic [SLOT_W-1:0]        slot_now;
  logic [FILL_W-1:0]        slots_filled;
  res_t                     expected_q [$];
  res_t                     oldest;

  // Apply one request to the shadow store and return the result it should give
  function automatic res_t apply_request(req_t r);
    res_t o;
    o = '0;
    case (r.mode)
      MODE_COUNT: begin
        if (r.event_type < NUM_TYPES)
          tally[slot_now][r.event_type] = tally[slot_now][r.event_type] + COUNTER_WIDTH'(1);
      end
      MODE_ADVANCE: begin
        slot_now = (slot_now == SLOT_W'(NUM_SLOTS - 1)) ? '0 : slot_now + SLOT_W'(1);
        for (int t = 0; t < NUM_TYPES; t++)
          tally[slot_now][t] = '0;
        if (slots_filled < NUM_SLOTS)
          slots_filled = slots_filled + FILL_W'(1);
        advances++;
      end
      MODE_READ: begin
        if (FILL_W'(r.read_interval) < slots_filled && r.read_type < NUM_TYPES) begin
          o.read_value = VALUE_W'(tally[r.read_interval][r.read_type]);
          o.read_valid = 1'b1;
          valid_reads++;
        end
      end
      default: ;
    endcase
    o.current_slot = slot_now;
    o.filled_slots = slots_filled;
    return o;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SLOTS; s++)
        for (int t = 0; t < NUM_TYPES; t++)
          tally[s][t] = '0;
      slot_now     = '0;
      slots_filled = '0;
      expected_q.delete();
      errors       = 0;
      valid_reads  = 0;
      advances     = 0;
    end else begin
      // Compare the result first: it can never belong to a request taken at this edge
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding: %p", result);
          errors++;
        end else begin
          oldest = expected_q.pop_front();
          if (result.read_value !== oldest.read_value) begin
            $error("read_value: expected %0h, got %0h", oldest.read_value, result.read_value);
            errors++;
          end
          if (result.read_valid !== oldest.read_valid) begin
            $error("read_valid: expected %0b, got %0b", oldest.read_valid, result.read_valid);
            errors++;
          end
          if (result.current_slot !== oldest.current_slot) begin
            $error("current_slot: expected %0d, got %0d",
                   oldest.current_slot, result.current_slot);
            errors++;
          end
          if (result.filled_slots !== oldest.filled_slots) begin
            $error("filled_slots: expected %0d, got %0d",
                   oldest.filled_slots, result.filled_slots);
            errors++;
          end
        end
      end
      // Predict the outcome of a request taken at this edge
      if (start && !busy)
        expected_q.push_back(apply_request(req));
    end
    pending = expected_q.size();
  end

endmodule

[test/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import iecr_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 1030;
  localparam int CALM_TAIL   = 150;
  localparam int DRAIN       = 20;
  localparam int LIMIT       = 200000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  res_t result;
  int   errors;
  int   pending;
  int   valid_reads;
  int   advances;
  int   cycles = 0;
  int   idle_pct = 0;
  int   sent = 0;

  interval_event_counter_ring_top dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  interval_event_counter_ring_checker watch (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .done        (done),
    .result      (result),
    .errors      (errors),
    .pending     (pending),
    .valid_reads (valid_reads),
    .advances    (advances)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic req_t make_req(logic [1:0] m, logic [TYPE_W-1:0] et,
                                    logic [SLOT_W-1:0] ri, logic [TYPE_W-1:0] rt);
    req_t r;
    r.mode          = m;
    r.event_type    = et;
    r.read_interval = ri;
    r.read_type     = rt;
    return r;
  endfunction

  // Mostly counts and reads, some advances, a few unused modes
  function automatic req_t random_req();
    int   pick;
    req_t r;
    pick            = $urandom_range(0, 99);
    r.event_type    = TYPE_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 15));
    r.read_interval = SLOT_W'($urandom_range(0, 7));
    r.read_type     = TYPE_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 15));
    if (pick < 55)
      r.mode = MODE_COUNT;
    else if (pick < 65)
      r.mode = MODE_ADVANCE;
    else if (pick < 95)
      r.mode = MODE_READ;
    else
      r.mode = MODE_UNUSED;
    return r;
  endfunction

  // Hold the request until it is taken, then maybe idle for a burst
  task automatic send(input req_t r);
    int gap;
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      req   <= random_req();
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unfilled reads, type extremes, unused mode, wrap and saturation
    idle_pct = 20;
    send(make_req(MODE_READ, 4'd0, 3'd0, 4'd0));
    send(make_req(MODE_COUNT, 4'd0, 3'd7, 4'd15));
    send(make_req(MODE_COUNT, 4'd15, 3'd0, 4'd0));
    send(make_req(MODE_COUNT, 4'd15, 3'd7, 4'd15));
    send(make_req(MODE_UNUSED, 4'd15, 3'd7, 4'd15));
    send(make_req(MODE_READ, 4'd0, 3'd0, 4'd15));
    send(make_req(MODE_ADVANCE, 4'd15, 3'd7, 4'd15));
    send(make_req(MODE_READ, 4'd0, 3'd0, 4'd15));
    send(make_req(MODE_READ, 4'd15, 3'd0, 4'd0));
    send(make_req(MODE_READ, 4'd0, 3'd7, 4'd15));
    send(make_req(MODE_COUNT, 4'd15, 3'd0, 4'd0));
    for (int i = 0; i < 8; i++)
      send(make_req(MODE_ADVANCE, 4'd0, 3'd0, 4'd0));
    send(make_req(MODE_READ, 4'd0, 3'd7, 4'd0));
    send(make_req(MODE_READ, 4'd0, 3'd1, 4'd15));
    send(make_req(MODE_COUNT, 4'd7, 3'd0, 4'd0));
    send(make_req(MODE_READ, 4'd0, 3'd1, 4'd7));
    send(make_req(MODE_READ, 4'd0, 3'd0, 4'd15));

    // Random: idling density changes in stretches, none in the tail
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i >= RANDOM_REQS - CALM_TAIL)
        idle_pct = 0;
      else if (i % 64 == 0)
        idle_pct = 20 * $urandom_range(0, 2);
      send(random_req());
    end
    start <= 1'b0;

    // Drain outstanding results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("summary: %0d requests checked, %0d interval advances, %0d valid counter reads",
             sent, advances, valid_reads);
    if (errors == 0 && pending == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
